>>> rtl/iqd_pkg.sv
// Package for the IQ sample code decoder.
// Widths, register indexes, encoding and format codes, shared types.
// No dependencies.
package iqd_pkg;

    // Field and register widths
    localparam int CODE_W     = 16;                 // raw code width
    localparam int Q_MAX      = 16;                 // widest supported quantization
    localparam int QIDX_W     = $clog2(Q_MAX);      // bit index into a raw code
    localparam int QB_W       = 5;                  // quantization_bits register
    localparam int ENC_W      = 4;                  // sample_encoding register
    localparam int FMT_W      = 4;                  // sample_format register
    localparam int VAL_W      = 17;                 // signed output value
    localparam int BASE_W     = 17;                 // decoded value before odd-level step
    localparam int WIDE_W     = VAL_W + 1;          // headroom for 2*b+1 and negation
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 5;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ENC = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_QB  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FMT = 2'd2;

    // Sample encodings
    localparam logic [ENC_W-1:0] ENC_SIGN       = 4'd0;
    localparam logic [ENC_W-1:0] ENC_OFFSET     = 4'd1;
    localparam logic [ENC_W-1:0] ENC_SIGN_MAG   = 4'd2;
    localparam logic [ENC_W-1:0] ENC_MAG_SIGN   = 4'd3;
    localparam logic [ENC_W-1:0] ENC_TWOS       = 4'd4;
    localparam logic [ENC_W-1:0] ENC_GRAY       = 4'd5;
    localparam logic [ENC_W-1:0] ENC_OFFSET_A   = 4'd6;
    localparam logic [ENC_W-1:0] ENC_SIGN_MAG_A = 4'd7;
    localparam logic [ENC_W-1:0] ENC_MAG_SIGN_A = 4'd8;
    localparam logic [ENC_W-1:0] ENC_TWOS_A     = 4'd9;
    localparam logic [ENC_W-1:0] ENC_GRAY_A     = 4'd10;

    // Sample formats
    localparam logic [FMT_W-1:0] FMT_IF   = 4'd0;
    localparam logic [FMT_W-1:0] FMT_IFN  = 4'd1;
    localparam logic [FMT_W-1:0] FMT_IQ   = 4'd2;
    localparam logic [FMT_W-1:0] FMT_IQN  = 4'd3;
    localparam logic [FMT_W-1:0] FMT_INQ  = 4'd4;
    localparam logic [FMT_W-1:0] FMT_INQN = 4'd5;
    localparam logic [FMT_W-1:0] FMT_QI   = 4'd6;
    localparam logic [FMT_W-1:0] FMT_QIN  = 4'd7;
    localparam logic [FMT_W-1:0] FMT_QNI  = 4'd8;
    localparam logic [FMT_W-1:0] FMT_QNIN = 4'd9;

    // Reset values
    localparam logic [ENC_W-1:0] ENC_RESET = ENC_TWOS;
    localparam logic [QB_W-1:0]  QB_RESET  = 5'd2;
    localparam logic [FMT_W-1:0] FMT_RESET = FMT_IQ;

    // Active configuration, quantization already clamped to 1..Q_MAX
    typedef struct packed {
        logic [ENC_W-1:0] enc;
        logic [QB_W-1:0]  q_eff;
        logic [FMT_W-1:0] fmt;
    } cfg_t;

    // Stage 1 result: masked codes and their Gray-to-binary conversions
    typedef struct packed {
        logic [CODE_W-1:0] raw_a;
        logic [CODE_W-1:0] raw_b;
        logic [CODE_W-1:0] bin_a;
        logic [CODE_W-1:0] bin_b;
    } prep_t;

    // Decoded code: value = (odd ? 2*base+1 : base), negated when neg
    typedef struct packed {
        logic signed [BASE_W-1:0] base;
        logic                     odd;
        logic                     neg;
    } dec_t;

    typedef struct packed {
        dec_t a;
        dec_t b;
    } dec_pair_t;

endpackage

>>> rtl/iqd_cfg.sv
// Configuration registers of the IQ sample code decoder.
// Holds encoding, quantization and format; clamps the quantization.
// Depends on iqd_pkg.
module iqd_cfg (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_write,
    input  logic [iqd_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [iqd_pkg::CFG_DATA_W-1:0]  cfg_data,
    output iqd_pkg::cfg_t                   cfg
);
    import iqd_pkg::*;

    logic [ENC_W-1:0] enc_reg;
    logic [QB_W-1:0]  qb_reg;
    logic [FMT_W-1:0] fmt_reg;

    // Register writes; an index past the list is ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enc_reg <= ENC_RESET;
            qb_reg  <= QB_RESET;
            fmt_reg <= FMT_RESET;
        end
        else if (cfg_write)
        begin
            if (cfg_index == CFG_ENC)
                enc_reg <= cfg_data[ENC_W-1:0];
            else if (cfg_index == CFG_QB)
                qb_reg <= cfg_data[QB_W-1:0];
            else if (cfg_index == CFG_FMT)
                fmt_reg <= cfg_data[FMT_W-1:0];
        end
    end

    // Zero acts as one bit, anything above Q_MAX as Q_MAX
    always_comb
    begin
        cfg.enc = enc_reg;
        cfg.fmt = fmt_reg;
        if (qb_reg == '0)
            cfg.q_eff = QB_W'(1);
        else if (qb_reg > QB_W'(Q_MAX))
            cfg.q_eff = QB_W'(Q_MAX);
        else
            cfg.q_eff = qb_reg;
    end

endmodule

>>> rtl/iqd_prep.sv
// Stage 1 of the IQ sample code decoder.
// Masks both codes to the quantization width and converts them from Gray.
// Depends on iqd_pkg.
module iqd_prep (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         load,
    input  logic                         in_valid,
    input  logic [iqd_pkg::CODE_W-1:0]   first_code,
    input  logic [iqd_pkg::CODE_W-1:0]   second_code,
    input  logic [iqd_pkg::QB_W-1:0]     q_eff,
    output logic                         valid,
    output iqd_pkg::prep_t               data
);
    import iqd_pkg::*;

    logic              valid_reg;
    logic              valid_next;
    prep_t             data_reg;
    prep_t             data_next;
    logic [CODE_W-1:0] mask;

    // Each binary bit is the parity of the Gray bits at and above it
    function automatic logic [CODE_W-1:0] gray_to_bin(input logic [CODE_W-1:0] g);
        logic [CODE_W-1:0] b;
        for (int i = 0; i < CODE_W; i++)
            b[i] = ^(g >> i);
        return b;
    endfunction

    // Low q bits kept
    always_comb
    begin
        for (int i = 0; i < CODE_W; i++)
            mask[i] = (QB_W'(i) < q_eff);
    end

    always_comb
    begin
        data_next.raw_a = first_code & mask;
        data_next.raw_b = second_code & mask;
        data_next.bin_a = gray_to_bin(first_code & mask);
        data_next.bin_b = gray_to_bin(second_code & mask);
        valid_next      = load ? in_valid : valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load && in_valid)
            data_reg <= data_next;
    end

    assign valid = valid_reg;
    assign data  = data_reg;

endmodule

>>> rtl/iqd_decode.sv
// Stage 2 of the IQ sample code decoder.
// Turns each masked code into a base value with odd-level and sign flags.
// Depends on iqd_pkg.
module iqd_decode (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         load,
    input  logic                         in_valid,
    input  iqd_pkg::prep_t               in_data,
    input  logic [iqd_pkg::ENC_W-1:0]    enc,
    input  logic [iqd_pkg::QB_W-1:0]     q_eff,
    output logic                         valid,
    output iqd_pkg::dec_pair_t           data
);
    import iqd_pkg::*;

    logic      valid_reg;
    logic      valid_next;
    dec_pair_t data_reg;
    dec_pair_t data_next;

    // One code by the configured encoding
    function automatic dec_t decode_one(
        input logic [CODE_W-1:0] raw,
        input logic [CODE_W-1:0] bin,
        input logic [ENC_W-1:0]  e,
        input logic [QB_W-1:0]   q
    );
        logic [QIDX_W-1:0]        qi;
        logic [CODE_W-1:0]        half;
        logic [CODE_W-1:0]        mag_mask;
        logic                     top;
        logic                     low;
        logic signed [WIDE_W-1:0] rawx;
        logic signed [WIDE_W-1:0] binx;
        logic signed [WIDE_W-1:0] halfx;
        logic signed [WIDE_W-1:0] sum;
        dec_t                     d;
        qi       = QIDX_W'(q - QB_W'(1));
        half     = CODE_W'(1) << qi;
        mag_mask = half - CODE_W'(1);
        top      = raw[qi];
        low      = raw[0];
        rawx     = signed'({2'b00, raw});
        binx     = signed'({2'b00, bin});
        halfx    = signed'({2'b00, half});
        sum      = '0;
        d.odd    = 1'b0;
        d.neg    = 1'b0;
        unique case (e) inside
            ENC_SIGN:
            begin
                // base zero, odd step gives one
                d.odd = 1'b1;
                d.neg = low;
            end
            ENC_OFFSET, ENC_OFFSET_A:
            begin
                sum   = rawx - halfx;
                d.odd = (e == ENC_OFFSET_A);
            end
            ENC_SIGN_MAG, ENC_SIGN_MAG_A:
            begin
                sum   = signed'({2'b00, raw & mag_mask});
                d.odd = (e == ENC_SIGN_MAG_A);
                d.neg = top;
            end
            ENC_MAG_SIGN, ENC_MAG_SIGN_A:
            begin
                sum   = signed'({2'b00, (raw >> 1) & mag_mask});
                d.odd = (e == ENC_MAG_SIGN_A);
                d.neg = low;
            end
            ENC_TWOS, ENC_TWOS_A:
            begin
                sum   = top ? (rawx - (halfx <<< 1)) : rawx;
                d.odd = (e == ENC_TWOS_A);
            end
            ENC_GRAY, ENC_GRAY_A:
            begin
                sum   = binx - halfx;
                d.odd = (e == ENC_GRAY_A);
            end
            default:
            begin
                // undefined encoding decodes to zero
                sum = '0;
            end
        endcase
        d.base = sum[BASE_W-1:0];
        return d;
    endfunction

    always_comb
    begin
        data_next.a = decode_one(in_data.raw_a, in_data.bin_a, enc, q_eff);
        data_next.b = decode_one(in_data.raw_b, in_data.bin_b, enc, q_eff);
        valid_next  = load ? in_valid : valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load && in_valid)
            data_reg <= data_next;
    end

    assign valid = valid_reg;
    assign data  = data_reg;

endmodule

>>> rtl/iqd_format.sv
// Stage 3 of the IQ sample code decoder and its output register.
// Applies the odd-level step, the sign and the I/Q order of the format.
// Depends on iqd_pkg.
module iqd_format (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              load,
    input  logic                              in_valid,
    input  iqd_pkg::dec_pair_t                in_data,
    input  logic [iqd_pkg::FMT_W-1:0]         fmt,
    output logic                              valid,
    output logic signed [iqd_pkg::VAL_W-1:0]  i_out,
    output logic signed [iqd_pkg::VAL_W-1:0]  q_out
);
    import iqd_pkg::*;

    typedef struct packed {
        logic swap;     // I from the second code, Q from the first
        logic neg_i;
        logic neg_q;
        logic real_f;   // quadrature forced to zero
        logic zero;     // undefined format: both zero
    } fmt_ctl_t;

    logic                    valid_reg;
    logic                    valid_next;
    logic signed [VAL_W-1:0] i_reg;
    logic signed [VAL_W-1:0] i_next;
    logic signed [VAL_W-1:0] q_reg;
    logic signed [VAL_W-1:0] q_next;
    fmt_ctl_t                ctl;
    dec_t                    src_i;
    dec_t                    src_q;

    // Final value: optional 2*b+1, then negation
    function automatic logic signed [VAL_W-1:0] finish(input dec_t d, input logic flip);
        logic signed [WIDE_W-1:0] b;
        logic signed [WIDE_W-1:0] v;
        logic signed [WIDE_W-1:0] r;
        b = WIDE_W'(d.base);
        v = d.odd ? ((b <<< 1) + WIDE_W'(1)) : b;
        r = flip ? -v : v;
        return r[VAL_W-1:0];
    endfunction

    // Format decoder
    always_comb
    begin
        ctl = '0;
        unique case (fmt)
            FMT_IF:   ctl.real_f = 1'b1;
            FMT_IFN:
            begin
                ctl.real_f = 1'b1;
                ctl.neg_i  = 1'b1;
            end
            FMT_IQ:   ctl = '0;
            FMT_IQN:  ctl.neg_q = 1'b1;
            FMT_INQ:  ctl.neg_i = 1'b1;
            FMT_INQN:
            begin
                ctl.neg_i = 1'b1;
                ctl.neg_q = 1'b1;
            end
            FMT_QI:   ctl.swap = 1'b1;
            FMT_QIN:
            begin
                ctl.swap  = 1'b1;
                ctl.neg_i = 1'b1;
            end
            FMT_QNI:
            begin
                ctl.swap  = 1'b1;
                ctl.neg_q = 1'b1;
            end
            FMT_QNIN:
            begin
                ctl.swap  = 1'b1;
                ctl.neg_i = 1'b1;
                ctl.neg_q = 1'b1;
            end
            default:  ctl.zero = 1'b1;
        endcase
    end

    // Order, sign and zeroing
    always_comb
    begin
        src_i  = ctl.swap ? in_data.b : in_data.a;
        src_q  = ctl.swap ? in_data.a : in_data.b;
        i_next = ctl.zero ? '0 : finish(src_i, src_i.neg ^ ctl.neg_i);
        q_next = (ctl.zero || ctl.real_f) ? '0 : finish(src_q, src_q.neg ^ ctl.neg_q);
        valid_next = load ? in_valid : valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load && in_valid)
        begin
            i_reg <= i_next;
            q_reg <= q_next;
        end
    end

    assign valid = valid_reg;
    assign i_out = i_reg;
    assign q_out = q_reg;

endmodule

>>> rtl/iq_sample_code_decoder.sv
// IQ sample code decoder, top level: three-stage pipeline with valid/stall
// on both sides. Accepts one code pair per clock while in_stall is low and
// returns one I/Q pair per pair. Stage 1 masks and Gray-converts the codes,
// stage 2 decodes them by the configured encoding, stage 3 applies the sample
// format and holds the result. Each stage loads whenever it is empty or the
// one after it is moving, so bubbles are squeezed out and a stall backs up
// without losing or repeating a transfer; the sustained rate is one pair per
// cycle while out_stall is low. Configuration is taken from the write port at
// any time but may change only while the pipeline is empty.
// Depends on iqd_pkg, iqd_cfg, iqd_prep, iqd_decode, iqd_format.
module iq_sample_code_decoder (
    input  logic                              clk,
    input  logic                              rst_n,
    // configuration
    input  logic                              cfg_write,
    input  logic [iqd_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [iqd_pkg::CFG_DATA_W-1:0]    cfg_data,
    // input channel
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [iqd_pkg::CODE_W-1:0]        first_code,
    input  logic [iqd_pkg::CODE_W-1:0]        second_code,
    // output channel
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic signed [iqd_pkg::VAL_W-1:0]  in_phase,
    output logic signed [iqd_pkg::VAL_W-1:0]  quadrature
);
    import iqd_pkg::*;

    cfg_t      cfg;
    prep_t     s1_data;
    dec_pair_t s2_data;
    logic      s1_valid;
    logic      s2_valid;
    logic      adv1;
    logic      adv2;
    logic      adv3;

    // Stage advance chain, output side first
    assign adv3     = !out_valid || !out_stall;
    assign adv2     = !s2_valid || adv3;
    assign adv1     = !s1_valid || adv2;
    assign in_stall = !adv1;

    iqd_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    iqd_prep u_prep (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (adv1),
        .in_valid    (in_valid),
        .first_code  (first_code),
        .second_code (second_code),
        .q_eff       (cfg.q_eff),
        .valid       (s1_valid),
        .data        (s1_data)
    );

    iqd_decode u_decode (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (adv2),
        .in_valid (s1_valid),
        .in_data  (s1_data),
        .enc      (cfg.enc),
        .q_eff    (cfg.q_eff),
        .valid    (s2_valid),
        .data     (s2_data)
    );

    iqd_format u_format (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (adv3),
        .in_valid (s2_valid),
        .in_data  (s2_data),
        .fmt      (cfg.fmt),
        .valid    (out_valid),
        .i_out    (in_phase),
        .q_out    (quadrature)
    );

endmodule

>>> rtl/iqd_checker.sv
// Port-level checks for the IQ sample code decoder, bound to the top level.
// Sees only the top-level ports. No package dependency.
module iqd_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               cfg_write,
    input logic [1:0]         cfg_index,
    input logic [4:0]         cfg_data,
    input logic               in_valid,
    input logic               in_stall,
    input logic [15:0]        first_code,
    input logic [15:0]        second_code,
    input logic               out_valid,
    input logic               out_stall,
    input logic signed [16:0] in_phase,
    input logic signed [16:0] quadrature
);

    // A held result keeps its value
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(in_phase) && $stable(quadrature))
    else $error("stalled result changed");

    // Without output backpressure the input side never stalls
    assert property (@(posedge clk) disable iff (!rst_n)
        !out_stall |-> !in_stall)
    else $error("input stalled while output is free");

    // An accepted pair reaches the output while the output side stays free
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) ##1 !out_stall ##1 !out_stall |=> out_valid)
    else $error("accepted pair did not reach the output");

    // Results stay inside +/-65535
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (in_phase != 17'h10000) && (quadrature != 17'h10000))
    else $error("result out of range");

endmodule

bind iq_sample_code_decoder iqd_checker u_iqd_checker (.*);

>>> dv/iq_sample_code_decoder_tb.sv
// Self-checking testbench for iq_sample_code_decoder: directed and random code pairs
// across all encodings, quantizations and formats, checked against an internal predictor.
// Depends on iqd_pkg and the iq_sample_code_decoder RTL.
module iq_sample_code_decoder_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import iqd_pkg::*;

    // Register index with no register behind it
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
    localparam int STALL_LIMIT = 1000;  // cycles with no transfer before giving up
    localparam int ITEMS_PER_SETTING = 40;
    localparam int SETTINGS_PER_PHASE = 5;

    typedef struct packed {
        logic signed [VAL_W-1:0] i_val;
        logic signed [VAL_W-1:0] q_val;
    } iq_pair_t;

    logic                     clk;
    logic                     rst_n;
    logic                     cfg_write;
    logic [CFG_IDX_W-1:0]     cfg_index;
    logic [CFG_DATA_W-1:0]    cfg_data;
    logic                     in_valid;
    logic                     in_stall;
    logic [CODE_W-1:0]        first_code;
    logic [CODE_W-1:0]        second_code;
    logic                     out_valid;
    logic                     out_stall = 1'b0;
    logic signed [VAL_W-1:0]  in_phase;
    logic signed [VAL_W-1:0]  quadrature;

    // Shadow copy of the configuration registers
    logic [ENC_W-1:0] enc_cfg;
    logic [QB_W-1:0]  qbits_cfg;
    logic [FMT_W-1:0] fmt_cfg;

    iq_pair_t iq_expected_q[$];
    int       send_gap_pct;
    int       stall_pct;
    int       pairs_sent;
    int       pairs_checked = 0;
    int       settings_count;
    int       err_count = 0;
    int       quiet_cycles = 0;

    iq_sample_code_decoder u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .first_code  (first_code),
        .second_code (second_code),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .in_phase    (in_phase),
        .quadrature  (quadrature)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Decode one raw code to its exact signed value
    function automatic longint decode_code(logic [CODE_W-1:0] code, logic [ENC_W-1:0] enc,
                                           int q);
        longint raw;
        longint mag;
        longint half;
        longint bin;
        longint m;
        logic   top;
        logic   low;
        raw  = longint'(code) & ((longint'(1) << q) - 1);
        mag  = (longint'(1) << (q - 1)) - 1;
        half = longint'(1) << (q - 1);
        top  = raw[q-1];
        low  = raw[0];
        // Gray to binary: xor of all right shifts
        bin = raw;
        for (int s = 1; s < CODE_W; s++)
            bin = bin ^ (raw >> s);
        case (enc)
            ENC_SIGN:       return low ? -1 : 1;
            ENC_OFFSET:     return raw - half;
            ENC_SIGN_MAG:
            begin
                m = raw & mag;
                return top ? -m : m;
            end
            ENC_MAG_SIGN:
            begin
                m = (raw >> 1) & mag;
                return low ? -m : m;
            end
            ENC_TWOS:       return top ? raw - 2 * half : raw;
            ENC_GRAY:       return bin - half;
            ENC_OFFSET_A:   return (raw - half) * 2 + 1;
            ENC_SIGN_MAG_A:
            begin
                m = ((raw & mag) << 1) | 1;
                return top ? -m : m;
            end
            ENC_MAG_SIGN_A:
            begin
                m = (((raw >> 1) & mag) << 1) | 1;
                return low ? -m : m;
            end
            ENC_TWOS_A:     return top ? (raw - 2 * half) * 2 + 1 : raw * 2 + 1;
            ENC_GRAY_A:     return (bin - half) * 2 + 1;
            default:        return 0;
        endcase
    endfunction

    function automatic logic signed [VAL_W-1:0] clip_value(longint v);
        if (v > 65535)
            v = 65535;
        if (v < -65535)
            v = -65535;
        return v[VAL_W-1:0];
    endfunction

    // Predict the I/Q pair for one code pair under the current configuration
    function automatic iq_pair_t predict_iq(logic [CODE_W-1:0] c0, logic [CODE_W-1:0] c1);
        int       q;
        longint   a;
        longint   b;
        longint   iv;
        longint   qv;
        iq_pair_t r;
        q = qbits_cfg;
        if (q < 1)
            q = 1;
        if (q > Q_MAX)
            q = Q_MAX;
        a  = decode_code(c0, enc_cfg, q);
        b  = decode_code(c1, enc_cfg, q);
        iv = 0;
        qv = 0;
        case (fmt_cfg)
            FMT_IF:   iv = a;
            FMT_IFN:  iv = -a;
            FMT_IQ:   begin iv = a;  qv = b;  end
            FMT_IQN:  begin iv = a;  qv = -b; end
            FMT_INQ:  begin iv = -a; qv = b;  end
            FMT_INQN: begin iv = -a; qv = -b; end
            FMT_QI:   begin iv = b;  qv = a;  end
            FMT_QIN:  begin iv = -b; qv = a;  end
            FMT_QNI:  begin iv = b;  qv = -a; end
            FMT_QNIN: begin iv = -b; qv = -a; end
            default:  ;
        endcase
        r.i_val = clip_value(iv);
        r.q_val = clip_value(qv);
        return r;
    endfunction

    // Receiver side: random stall, changed at the falling edge
    always @(negedge clk)
        out_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);

    // Monitor: predict on input transfers, check output transfers, watchdog
    always @(posedge clk)
    begin
        iq_pair_t exp_pair;
        logic     moved;
        if (rst_n)
        begin
            moved = 1'b0;
            if (in_valid && !in_stall)
            begin
                iq_expected_q.insert(iq_expected_q.size(),
                                     predict_iq(first_code, second_code));
                moved = 1'b1;
            end
            if (out_valid && !out_stall)
            begin
                moved = 1'b1;
                if (iq_expected_q.size() == 0)
                begin
                    err_count++;
                    $display("%0t: unexpected transfer I=%0d Q=%0d", $time,
                             in_phase, quadrature);
                end
                else
                begin
                    exp_pair = iq_expected_q.pop_front();
                    pairs_checked++;
                    if (in_phase !== exp_pair.i_val)
                    begin
                        err_count++;
                        $display("%0t: in_phase expected %0d actual %0d", $time,
                                 exp_pair.i_val, in_phase);
                    end
                    if (quadrature !== exp_pair.q_val)
                    begin
                        err_count++;
                        $display("%0t: quadrature expected %0d actual %0d", $time,
                                 exp_pair.q_val, quadrature);
                    end
                end
            end
            quiet_cycles = moved ? 0 : quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("%0t: timeout, no transfer for %0d cycles", $time, STALL_LIMIT);
                $display("iq_sample_code_decoder: mismatch");
                $finish;
            end
        end
    end

    // Write all registers back to back, then poke the spare index
    task automatic apply_config(logic [CFG_DATA_W-1:0] enc, logic [CFG_DATA_W-1:0] qb,
                                logic [CFG_DATA_W-1:0] fmt);
        cfg_write <= 1'b1;
        cfg_index <= CFG_ENC;
        cfg_data  <= enc;
        @(negedge clk);
        cfg_index <= CFG_QB;
        cfg_data  <= qb;
        @(negedge clk);
        cfg_index <= CFG_FMT;
        cfg_data  <= fmt;
        @(negedge clk);
        cfg_index <= CFG_SPARE;
        cfg_data  <= CFG_DATA_W'($urandom);
        @(negedge clk);
        cfg_write <= 1'b0;
        enc_cfg   = enc[ENC_W-1:0];
        qbits_cfg = qb;
        fmt_cfg   = fmt[FMT_W-1:0];
        settings_count++;
        @(negedge clk);
    endtask

    // Send one code pair; returns at the falling edge after the transfer
    task automatic send_pair(logic [CODE_W-1:0] c0, logic [CODE_W-1:0] c1);
        while ((send_gap_pct != 0) && ($urandom_range(99) < send_gap_pct))
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid    <= 1'b1;
        first_code  <= c0;
        second_code <= c1;
        do
            @(posedge clk);
        while (in_stall);
        pairs_sent++;
        @(negedge clk);
    endtask

    // Hold off the sender until every expected pair has come back
    task automatic drain_pipeline();
        in_valid <= 1'b0;
        while (iq_expected_q.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // Reset configuration: two's complement, q = 2, IQ
    task automatic test_reset_config();
        send_pair(16'h0000, 16'hFFFF);
        send_pair(16'h0001, 16'h0002);
        send_pair(16'h0003, 16'hFFFE);
        send_pair(16'h5555, 16'hAAAA);
        drain_pipeline();
    endtask

    // Every encoding once, with formats permuted and quantizations varied over corner codes
    task automatic test_each_encoding_format();
        logic [CODE_W-1:0]     corner[4];
        logic [CFG_DATA_W-1:0] q_list[16];
        corner = '{16'h0000, 16'hFFFF, 16'h8000, 16'h7FFF};
        q_list = '{5'd1, 5'd16, 5'd0, 5'd31, 5'd2, 5'd17, 5'd3, 5'd8,
                   5'd16, 5'd1, 5'd4, 5'd15, 5'd16, 5'd5, 5'd1, 5'd12};
        send_gap_pct = 0;
        stall_pct    = 0;
        for (int k = 0; k < 16; k++)
        begin
            apply_config(CFG_DATA_W'(k), q_list[k], CFG_DATA_W'((k * 7) % 16));
            send_pair(corner[k % 4], corner[(k + 1) % 4]);
            drain_pipeline();
        end
    endtask

    // Random settings and random codes under one idle/stall mix
    task automatic test_random_traffic(int gap_pct, int stall_rate);
        logic [CFG_DATA_W-1:0] enc;
        logic [CFG_DATA_W-1:0] qb;
        logic [CFG_DATA_W-1:0] fmt;
        send_gap_pct = gap_pct;
        stall_pct    = stall_rate;
        for (int s = 0; s < SETTINGS_PER_PHASE; s++)
        begin
            // mostly defined encodings and formats, some undefined or with bit 4 set
            enc = ($urandom_range(9) == 0) ? CFG_DATA_W'($urandom_range(11, 31))
                                           : CFG_DATA_W'($urandom_range(0, 10));
            fmt = ($urandom_range(9) == 0) ? CFG_DATA_W'($urandom_range(10, 31))
                                           : CFG_DATA_W'($urandom_range(0, 9));
            case ($urandom_range(5))
                0:       qb = 5'd1;
                1:       qb = 5'd16;
                2:       qb = 5'd0;
                3:       qb = CFG_DATA_W'($urandom_range(17, 31));
                default: qb = CFG_DATA_W'($urandom_range(2, 15));
            endcase
            apply_config(enc, qb, fmt);
            for (int n = 0; n < ITEMS_PER_SETTING; n++)
                send_pair(CODE_W'($urandom), CODE_W'($urandom));
            drain_pipeline();
        end
    endtask

    initial
    begin
        rst_n          = 1'b0;
        cfg_write      = 1'b0;
        cfg_index      = CFG_ENC;
        cfg_data       = '0;
        in_valid       = 1'b0;
        first_code     = '0;
        second_code    = '0;
        send_gap_pct   = 0;
        stall_pct      = 0;
        pairs_sent     = 0;
        settings_count = 0;
        enc_cfg        = ENC_RESET;
        qbits_cfg      = QB_RESET;
        fmt_cfg        = FMT_RESET;
        repeat (2) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_reset_config();
        test_each_encoding_format();
        test_random_traffic(0, 0);
        test_random_traffic(48, 0);
        test_random_traffic(0, 48);
        test_random_traffic(31, 31);

        drain_pipeline();
        repeat (8) @(negedge clk);
        $display("Covered %0d code pairs (%0d checked) over %0d register settings,",
                 pairs_sent, pairs_checked, settings_count);
        $display("all encodings and formats, quantization 0 to 31, with sender gaps and stalls.");
        if (err_count == 0)
            $display("iq_sample_code_decoder: match");
        else
            $display("iq_sample_code_decoder: mismatch");
        $finish;
    end

endmodule
